>>> rtl/rpii_pkg.sv
// Shared types, constants and codes for the RGB product integral image block.
package rpii_pkg;

    // Default geometry limits for the top-level parameters.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Field and register widths.
    localparam int CHAN_W   = 8;
    localparam int REG_W    = 11;
    localparam int SIZE_W   = 13;
    localparam int SUM_W    = 30;
    localparam int PROD1_W  = 2 * CHAN_W;
    localparam int PROD2_W  = 3 * CHAN_W;
    localparam int GREY_SHIFT = 14;
    localparam int GREY_W   = PROD2_W - GREY_SHIFT;

    // Register reset value for both size registers.
    localparam logic [REG_W-1:0] SIZE_RESET = REG_W'(1024);

    // Configuration register indexes.
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    // Pixel sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM
    } t_state;

    // Control from the sequencer to the row-sum memory unit.
    typedef struct packed {
        logic rd_en;
        logic commit;
        logic first_row;
        logic last_col;
    } t_sum_ctl;

endpackage

>>> rtl/rpii_grey.sv
// Two-stage multiplier that forms the grey value red * green * blue / 16384.
module rpii_grey (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  logic                              i_step,
    input  logic [rpii_pkg::CHAN_W-1:0]       i_red,
    input  logic [rpii_pkg::CHAN_W-1:0]       i_green,
    input  logic [rpii_pkg::CHAN_W-1:0]       i_blue,
    output logic [rpii_pkg::GREY_W-1:0]       o_grey
);

    logic [rpii_pkg::PROD1_W-1:0] r_rg;
    logic [rpii_pkg::CHAN_W-1:0]  r_b;
    logic [rpii_pkg::GREY_W-1:0]  r_grey;
    logic [rpii_pkg::PROD2_W-1:0] w_prod;

    // First product is registered before the second multiplication.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rg <= rpii_pkg::PROD1_W'(i_red) * rpii_pkg::PROD1_W'(i_green);
            r_b  <= i_blue;
        end
    end

    // Full product; the floor division is a plain drop of the low bits.
    assign w_prod = rpii_pkg::PROD2_W'(r_rg) * rpii_pkg::PROD2_W'(r_b);

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_grey <= w_prod[rpii_pkg::PROD2_W-1:rpii_pkg::GREY_SHIFT];
        end
    end

    assign o_grey = r_grey;

endmodule

>>> rtl/rpii_sum_mem.sv
// Row-above memory with the running row sum and the read-modify-write adder.
module rpii_sum_mem #(
    parameter int MAX_WIDTH = rpii_pkg::DEF_MAX_WIDTH,
    parameter int COL_W     = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rpii_pkg::t_sum_ctl              i_ctl,
    input  logic [COL_W-1:0]                i_col,
    input  logic [rpii_pkg::GREY_W-1:0]     i_grey,
    output logic [rpii_pkg::SUM_W-1:0]      o_sum
);

    logic [rpii_pkg::SUM_W-1:0] r_mem [MAX_WIDTH];
    logic [rpii_pkg::SUM_W-1:0] r_rd_data;
    logic [COL_W-1:0]           r_addr;
    logic [rpii_pkg::SUM_W-1:0] r_run;
    logic [rpii_pkg::SUM_W-1:0] n_run;
    logic [rpii_pkg::SUM_W-1:0] w_sum;

    // Synchronous read of the row above; the address is kept for write-back.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_col];
            r_addr    <= i_col;
        end
    end

    // Add the grey value to the row sum, then, except on the first row, the stored value of the row above.
    always_comb begin
        n_run = r_run + rpii_pkg::SUM_W'(i_grey);
        if (i_ctl.first_row) begin
            w_sum = n_run;
        end else begin
            w_sum = n_run + r_rd_data;
        end
    end

    // Write the new value back as the row above for the next row.
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_mem[r_addr] <= w_sum;
        end
    end

    // The running sum restarts at the beginning of every row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (i_ctl.commit) begin
            r_run <= i_ctl.last_col ? '0 : n_run;
        end
    end

    assign o_sum = w_sum;

endmodule

>>> rtl/rgb_product_integral_image.sv
// Top level of the RGB product integral image block: sequencer, position and output register.
//
// Pixels enter on the s_axis channel in raster order, red, green and blue in
// tdata. For each pixel one beat leaves on m_axis: the summed-area value of
// the grey value red*green*blue/16384, with tlast high on the last pixel of
// the image. image_width and image_height are set through the write port,
// index 0 and 1; zero acts as one and values above the limits are clamped.
// Write them only while no pixel is in flight.
//
// Each beat leaves once its pixel has passed the sequencer states: on acceptance
// the first product is registered and the memory read starts, in the multiply
// state the second product is registered, and in the sum state the add, the
// write-back to the row memory and the load of the output register are done. A new
// pixel is taken only once the last one is written back, so the read-modify-write
// of the row memory finishes before the next read starts.
// While the output register holds an untaken beat, one more pixel is taken
// and processed, then waits in the add stage until the receiver takes the beat.
// Reset clears the position, the running sum and the output valid flag and
// sets both sizes to 1024; the row memory is not cleared, since the first
// row of each image never uses what is read from it.
module rgb_product_integral_image #(
    parameter int MAX_WIDTH  = rpii_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rpii_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [23:0]                  s_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [31:0]                  m_axis_tdata,  // area_sum [29:0], zero [31:30]
    output logic                         m_axis_tlast,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [rpii_pkg::REG_W-1:0]   i_cfg_data
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SIZE_W = rpii_pkg::SIZE_W;

    rpii_pkg::t_state   r_state;
    rpii_pkg::t_state   n_state;
    rpii_pkg::t_sum_ctl w_ctl;

    logic [rpii_pkg::REG_W-1:0]  r_width;
    logic [rpii_pkg::REG_W-1:0]  r_height;
    logic [COL_W-1:0]            r_col;
    logic [ROW_W-1:0]            r_row;
    logic                        r_out_valid;
    logic [rpii_pkg::SUM_W-1:0]  r_out_sum;
    logic                        r_out_last;

    logic [SIZE_W-1:0]           w_width_eff;
    logic [SIZE_W-1:0]           w_height_eff;
    logic                        w_last_col;
    logic                        w_last_row;
    logic                        w_in_fire;
    logic                        w_fire;
    logic [rpii_pkg::GREY_W-1:0] w_grey;
    logic [rpii_pkg::SUM_W-1:0]  w_sum;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rpii_pkg::SIZE_RESET;
            r_height <= rpii_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rpii_pkg::CFG_IDX_WIDTH:  r_width  <= i_cfg_data;
                rpii_pkg::CFG_IDX_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective sizes: zero acts as one, oversize is clamped to the limit.
    always_comb begin
        if (r_width == '0) begin
            w_width_eff = SIZE_W'(1);
        end else if (SIZE_W'(r_width) > SIZE_W'(MAX_WIDTH)) begin
            w_width_eff = SIZE_W'(MAX_WIDTH);
        end else begin
            w_width_eff = SIZE_W'(r_width);
        end
        if (r_height == '0) begin
            w_height_eff = SIZE_W'(1);
        end else if (SIZE_W'(r_height) > SIZE_W'(MAX_HEIGHT)) begin
            w_height_eff = SIZE_W'(MAX_HEIGHT);
        end else begin
            w_height_eff = SIZE_W'(r_height);
        end
    end

    assign w_last_col = (SIZE_W'(r_col) + SIZE_W'(1)) >= w_width_eff;
    assign w_last_row = (SIZE_W'(r_row) + SIZE_W'(1)) >= w_height_eff;

    // Next-state logic of the pixel sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rpii_pkg::ST_IDLE: if (s_axis_tvalid) n_state = rpii_pkg::ST_MUL;
            rpii_pkg::ST_MUL:  n_state = rpii_pkg::ST_SUM;
            rpii_pkg::ST_SUM:  if (!r_out_valid || m_axis_tready) n_state = rpii_pkg::ST_IDLE;
            default:           n_state = rpii_pkg::ST_IDLE;
        endcase
    end

    // Output decode of the pixel sequencer.
    always_comb begin
        s_axis_tready = 1'b0;
        w_fire        = 1'b0;
        case (r_state)
            rpii_pkg::ST_IDLE: s_axis_tready = 1'b1;
            rpii_pkg::ST_SUM:  w_fire = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    assign w_in_fire       = s_axis_tvalid && s_axis_tready;
    assign w_ctl.rd_en     = w_in_fire;
    assign w_ctl.commit    = w_fire;
    assign w_ctl.first_row = (r_row == '0);
    assign w_ctl.last_col  = w_last_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpii_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Raster position, advanced when a pixel's result is committed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_fire) begin
            if (w_last_col) begin
                r_col <= '0;
                r_row <= w_last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    rpii_grey u_grey (
        .i_clk   (i_clk),
        .i_load  (w_in_fire),
        .i_step  (r_state == rpii_pkg::ST_MUL),
        .i_red   (s_axis_tdata[7:0]),
        .i_green (s_axis_tdata[15:8]),
        .i_blue  (s_axis_tdata[23:16]),
        .o_grey  (w_grey)
    );

    rpii_sum_mem #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_sum_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_col   (r_col),
        .i_grey  (w_grey),
        .o_sum   (w_sum)
    );

    // Output register: valid is control, the payload loads on commit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_sum  <= w_sum;
            r_out_last <= w_last_col && w_last_row;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_sum};
    assign m_axis_tlast  = r_out_last;

    // An accepted pixel always moves on to the multiply stage.
    a_accept_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_state == rpii_pkg::ST_MUL))
        else $error("accepted pixel did not enter the multiply stage");

    // No new pixel is taken while one is still being processed.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != rpii_pkg::ST_IDLE) |-> !s_axis_tready)
        else $error("input ready while a pixel is in flight");

    // Commit never overwrites an output beat that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !w_fire)
        else $error("output beat overwritten");

    // The last pixel of the image returns the position to the origin.
    a_image_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_last_col && w_last_row) |=> (r_col == '0 && r_row == '0))
        else $error("position not cleared after the last pixel");

    // Inside a row the column steps by one per committed pixel.
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !w_last_col) |=> (r_col == $past(r_col) + COL_W'(1)))
        else $error("column did not advance by one");

endmodule
